// ----- src/s2dh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2dh_pkg: shared types and constants of the sparse 2-D histogram table
// Table geometry, field widths, opcodes, status codes, state encodings and
// the saturating pack helper used by the arithmetic unit.
// ----------------------------------------------------------------------------
package s2dh_pkg;

   // table geometry
   localparam int BUCKET_COUNT   = 1024;
   localparam int ENTRY_CAPACITY = 4096;
   localparam int BKT_W = $clog2(BUCKET_COUNT);
   localparam int IDX_W = $clog2(ENTRY_CAPACITY);
   localparam int PTR_W = $clog2(ENTRY_CAPACITY + 1);   // index plus one, zero is null

   // field widths
   localparam int OP_W     = 3;
   localparam int KEY_W    = 32;
   localparam int WEIGHT_W = 48;
   localparam int STATUS_W = 2;
   localparam int MAG_W    = 80;   // widest magnitude handed to the pack step

   // hash
   localparam logic [KEY_W-1:0] HASH_MASK  = 32'h7fff_ffff;
   localparam int               HASH_SHIFT = 10;

   // saturation bounds, raw Q32.16
   localparam logic [WEIGHT_W-1:0] POS_MAX = 48'h7fff_ffff_ffff;
   localparam logic [WEIGHT_W-1:0] NEG_MAX = 48'h8000_0000_0000;

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 3'd0,
      OP_SET = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_GET = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_DIV0 = 2'd2,
      ST_SAT  = 2'd3
   } status_type;

   // one pool entry as stored in the entry RAM
   typedef struct packed {
      logic [KEY_W-1:0]    key_x;
      logic [KEY_W-1:0]    key_y;
      logic [WEIGHT_W-1:0] weight;
      logic [PTR_W-1:0]    next;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_HEAD,
      CS_PTR,
      CS_ENT,
      CS_MISS,
      CS_EXEC,
      CS_WAIT,
      CS_WRITE
   } ctl_state_type;

   typedef enum logic [2:0] {
      AS_IDLE,
      AS_PREP,
      AS_MUL,
      AS_DIV,
      AS_PACK,
      AS_DONE
   } ar_state_type;

   // controller to arithmetic unit
   typedef struct packed {
      logic                start;
      logic [OP_W-1:0]     op;
      logic [WEIGHT_W-1:0] a;
      logic [WEIGHT_W-1:0] b;
   } ar_req_type;

   // arithmetic unit to controller
   typedef struct packed {
      logic                done;
      logic [WEIGHT_W-1:0] weight;
      status_type          status;
   } ar_rsp_type;

   // sign and magnitude to a 48-bit weight; msb of the result flags saturation
   function automatic logic [WEIGHT_W:0] pack_weight(input logic neg,
                                                     input logic [MAG_W-1:0] mag);
      logic                sat;
      logic [WEIGHT_W-1:0] w;
      if (!neg) begin
         sat = mag > MAG_W'(POS_MAX);
         w   = sat ? POS_MAX : mag[WEIGHT_W-1:0];
      end else begin
         sat = mag > MAG_W'(NEG_MAX);
         w   = sat ? NEG_MAX : (~mag[WEIGHT_W-1:0] + 1'b1);
      end
      return {sat, w};
   endfunction

endpackage

// ----- src/s2dh_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2dh channel interfaces
// Valid/ready request and response channels of the histogram table.
// ----------------------------------------------------------------------------
interface s2dh_req_if
   import s2dh_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            opcode;
   logic signed [KEY_W-1:0]    key_x;
   logic signed [KEY_W-1:0]    key_y;
   logic signed [WEIGHT_W-1:0] operand_value;

   modport source (output valid, opcode, key_x, key_y, operand_value, input ready);
   modport sink   (input valid, opcode, key_x, key_y, operand_value, output ready);
endinterface

interface s2dh_rsp_if
   import s2dh_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [WEIGHT_W-1:0] weight_out;
   logic [STATUS_W-1:0]        status;

   modport source (output valid, weight_out, status, input ready);
   modport sink   (input valid, weight_out, status, output ready);
endinterface

// ----- src/s2dh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2dh_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module s2dh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/s2dh_arith.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2dh_arith: weight update unit
// Add/set in one pass, multiply as three 48x16 partial products, divide as a
// restoring divider retiring one quotient bit per cycle. Results saturate.
// ----------------------------------------------------------------------------
module s2dh_arith
   import s2dh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  ar_req_type ar_req,
   output ar_rsp_type ar_rsp
);

   localparam int ACC_W = 2 * WEIGHT_W;
   localparam int DQ_W  = WEIGHT_W + 16;
   localparam int CNT_W = $clog2(DQ_W);
   localparam int CHUNK = 16;

   ar_state_type state_ff, state_in;

   logic [OP_W-1:0]     op_ff;
   logic [WEIGHT_W-1:0] a_ff, b_ff;
   logic [WEIGHT_W-1:0] ma_ff, mb_ff;
   logic                neg_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [DQ_W-1:0]     dq_ff;
   logic [WEIGHT_W-1:0] rem_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [WEIGHT_W-1:0] res_w_ff;
   status_type          res_st_ff;

   // magnitudes of the latched operands
   logic [WEIGHT_W-1:0] ma, mb;
   assign ma = a_ff[WEIGHT_W-1] ? (~a_ff + 1'b1) : a_ff;
   assign mb = b_ff[WEIGHT_W-1] ? (~b_ff + 1'b1) : b_ff;

   // saturating add
   logic [WEIGHT_W:0]   sum;
   logic                add_sat;
   logic [WEIGHT_W-1:0] add_w;
   assign sum     = {a_ff[WEIGHT_W-1], a_ff} + {b_ff[WEIGHT_W-1], b_ff};
   assign add_sat = sum[WEIGHT_W] ^ sum[WEIGHT_W-1];
   assign add_w   = add_sat ? (sum[WEIGHT_W] ? NEG_MAX : POS_MAX) : sum[WEIGHT_W-1:0];

   // multiply step: top chunk of the remaining multiplier
   logic [WEIGHT_W+CHUNK-1:0] pp;
   assign pp = ma_ff * mb_ff[WEIGHT_W-1 -: CHUNK];

   // divide step
   logic [WEIGHT_W:0] shifted, diff;
   logic              ge;
   assign shifted = {rem_ff, dq_ff[DQ_W-1]};
   assign diff    = shifted - {1'b0, mb_ff};
   assign ge      = shifted >= {1'b0, mb_ff};

   // final pack
   logic [MAG_W-1:0]  mag;
   logic [WEIGHT_W:0] packed_w;
   assign mag      = (op_ff == OP_MUL) ? acc_ff[ACC_W-1:CHUNK] : MAG_W'(dq_ff);
   assign packed_w = pack_weight(neg_ff, mag);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         AS_IDLE: if (ar_req.start) state_in = AS_PREP;
         AS_PREP: begin
            if (op_ff == OP_MUL) begin
               state_in = AS_MUL;
            end else if (op_ff == OP_DIV && b_ff != '0) begin
               state_in = AS_DIV;
            end else begin
               state_in = AS_DONE;
            end
         end
         AS_MUL:  if (cnt_ff == CNT_W'(WEIGHT_W / CHUNK - 1)) state_in = AS_PACK;
         AS_DIV:  if (cnt_ff == CNT_W'(DQ_W - 1)) state_in = AS_PACK;
         AS_PACK: state_in = AS_DONE;
         AS_DONE: state_in = AS_IDLE;
         default: state_in = AS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ar_rsp.done   = (state_ff == AS_DONE);
      ar_rsp.weight = res_w_ff;
      ar_rsp.status = res_st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         AS_IDLE: begin
            if (ar_req.start) begin
               op_ff <= ar_req.op;
               a_ff  <= ar_req.a;
               b_ff  <= ar_req.b;
            end
         end
         AS_PREP: begin
            ma_ff  <= ma;
            mb_ff  <= mb;
            neg_ff <= a_ff[WEIGHT_W-1] ^ b_ff[WEIGHT_W-1];
            acc_ff <= '0;
            dq_ff  <= {ma, CHUNK'(0)};
            rem_ff <= '0;
            cnt_ff <= '0;
            if (op_ff == OP_ADD) begin
               res_w_ff  <= add_w;
               res_st_ff <= add_sat ? ST_SAT : ST_OK;
            end else if (op_ff == OP_SET) begin
               res_w_ff  <= b_ff;
               res_st_ff <= ST_OK;
            end else begin
               // divide by zero keeps the weight
               res_w_ff  <= a_ff;
               res_st_ff <= ST_DIV0;
            end
         end
         AS_MUL: begin
            acc_ff <= (acc_ff << CHUNK) + ACC_W'(pp);
            mb_ff  <= mb_ff << CHUNK;
            cnt_ff <= cnt_ff + 1'b1;
         end
         AS_DIV: begin
            rem_ff <= ge ? diff[WEIGHT_W-1:0] : shifted[WEIGHT_W-1:0];
            dq_ff  <= {dq_ff[DQ_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
         end
         AS_PACK: begin
            res_w_ff  <= packed_w[WEIGHT_W-1:0];
            res_st_ff <= packed_w[WEIGHT_W] ? ST_SAT : ST_OK;
         end
         AS_DONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- src/sparse_2d_histogram_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_2d_histogram_table_unit: chained hash table weight accumulator
// Sparse histogram keyed by (key_x, key_y), chained hash table in RAM.
// ----------------------------------------------------------------------------
// After reset the block clears all 1024 bucket heads and accepts no request
// until that sweep is done. Requests are then handled one at a time: lookup
// reads the bucket head, then reads the entry RAM once per chain entry
// visited, and a key that is not found passes through a miss step. Then get
// goes straight to write-back, while add, set, multiply (three 48x16 partial
// products) and divide (restoring divider, one quotient bit per cycle) run in
// the arithmetic unit. A finished response sits in an output register, so
// the next request is taken while it waits for ready.
// ----------------------------------------------------------------------------
module sparse_2d_histogram_table_unit
   import s2dh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   s2dh_req_if.sink     req_bus,
   s2dh_rsp_if.source   rsp_bus
);

   ctl_state_type state_ff, state_in;

   logic [OP_W-1:0]     op_ff;
   logic [KEY_W-1:0]    kx_ff, ky_ff;
   logic [WEIGHT_W-1:0] val_ff;
   logic [BKT_W-1:0]    bkt_ff;
   logic [PTR_W-1:0]    ptr_ff, head_ff, next_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [WEIGHT_W-1:0] wgt_ff;
   logic                new_ff, wr_ff;
   logic [PTR_W-1:0]    used_ff;
   logic [BKT_W-1:0]    clr_ff;
   logic [WEIGHT_W-1:0] res_w_ff;
   status_type          res_st_ff;
   logic                rsp_valid_ff;
   logic [WEIGHT_W-1:0] rsp_w_ff;
   status_type          rsp_st_ff;

   // RAM ports
   logic               head_wr_en, head_rd_en;
   logic [BKT_W-1:0]   head_wr_addr;
   logic [PTR_W-1:0]   head_wr_data, head_rd;
   logic               ent_wr_en, ent_rd_en;
   logic [IDX_W-1:0]   ent_rd_addr;
   entry_type          ent_wr_data, ent_rd;
   logic [ENTRY_W-1:0] ent_rd_raw;

   ar_req_type ar_req;
   ar_rsp_type ar_rsp;

   // bucket of the incoming key
   logic [KEY_W-1:0] hash;
   assign hash = ((req_bus.key_x << HASH_SHIFT) ^ req_bus.key_y) & HASH_MASK;

   // decoded request
   logic is_get, hit, slot_free, pool_full;
   assign is_get    = (op_ff != OP_ADD) && (op_ff != OP_SET) &&
                      (op_ff != OP_MUL) && (op_ff != OP_DIV);
   assign ent_rd    = entry_type'(ent_rd_raw);
   assign hit       = (ent_rd.key_x == kx_ff) && (ent_rd.key_y == ky_ff);
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign pool_full = (used_ff == PTR_W'(ENTRY_CAPACITY));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_CLEAR: if (clr_ff == BKT_W'(BUCKET_COUNT - 1)) state_in = CS_IDLE;
         CS_IDLE:  if (req_bus.valid) state_in = CS_HEAD;
         CS_HEAD:  state_in = CS_PTR;
         CS_PTR:   state_in = (head_rd == '0) ? CS_MISS : CS_ENT;
         CS_ENT: begin
            if (hit) begin
               state_in = is_get ? CS_WRITE : CS_EXEC;
            end else if (ent_rd.next == '0) begin
               state_in = CS_MISS;
            end
         end
         CS_MISS:  state_in = (is_get || pool_full) ? CS_WRITE : CS_EXEC;
         CS_EXEC:  state_in = CS_WAIT;
         CS_WAIT:  if (ar_rsp.done) state_in = CS_WRITE;
         CS_WRITE: if (slot_free) state_in = CS_IDLE;
         default:  state_in = CS_IDLE;
      endcase
   end

   // outputs and RAM controls
   always_comb begin
      req_bus.ready = (state_ff == CS_IDLE);
      head_wr_en    = 1'b0;
      head_wr_addr  = bkt_ff;
      head_wr_data  = PTR_W'(idx_ff) + 1'b1;
      head_rd_en    = (state_ff == CS_HEAD);
      ent_rd_en     = 1'b0;
      ent_rd_addr   = IDX_W'(head_rd - 1'b1);
      ent_wr_en     = 1'b0;
      ent_wr_data   = '{key_x: kx_ff, key_y: ky_ff, weight: res_w_ff, next: next_ff};
      ar_req        = '{start: (state_ff == CS_EXEC), op: op_ff, a: wgt_ff, b: val_ff};
      unique case (state_ff)
         CS_CLEAR: begin
            head_wr_en   = 1'b1;
            head_wr_addr = clr_ff;
            head_wr_data = '0;
         end
         CS_PTR: ent_rd_en = (head_rd != '0);
         CS_ENT: begin
            ent_rd_en   = !hit && (ent_rd.next != '0);
            ent_rd_addr = IDX_W'(ent_rd.next - 1'b1);
         end
         CS_WRITE: begin
            ent_wr_en  = slot_free && wr_ff;
            head_wr_en = slot_free && new_ff;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == CS_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == CS_WRITE && slot_free) begin
            rsp_valid_ff <= 1'b1;
            if (new_ff) begin
               used_ff <= used_ff + 1'b1;
            end
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         CS_IDLE: begin
            op_ff  <= req_bus.opcode;
            kx_ff  <= req_bus.key_x;
            ky_ff  <= req_bus.key_y;
            val_ff <= req_bus.operand_value;
            bkt_ff <= BKT_W'(hash % BUCKET_COUNT);
         end
         CS_PTR: begin
            head_ff <= head_rd;
            ptr_ff  <= head_rd;
         end
         CS_ENT: begin
            if (hit) begin
               idx_ff    <= IDX_W'(ptr_ff - 1'b1);
               wgt_ff    <= ent_rd.weight;
               next_ff   <= ent_rd.next;
               new_ff    <= 1'b0;
               wr_ff     <= 1'b0;
               res_w_ff  <= ent_rd.weight;
               res_st_ff <= ST_OK;
            end else begin
               ptr_ff <= ent_rd.next;
            end
         end
         CS_MISS: begin
            idx_ff   <= IDX_W'(used_ff);
            wgt_ff   <= '0;
            next_ff  <= head_ff;
            new_ff   <= !is_get && !pool_full;
            wr_ff    <= 1'b0;
            res_w_ff <= '0;
            res_st_ff <= (!is_get && pool_full) ? ST_FULL : ST_OK;
         end
         CS_WAIT: begin
            if (ar_rsp.done) begin
               res_w_ff  <= ar_rsp.weight;
               res_st_ff <= ar_rsp.status;
               wr_ff     <= 1'b1;
            end
         end
         CS_WRITE: begin
            if (slot_free) begin
               rsp_w_ff  <= res_w_ff;
               rsp_st_ff <= res_st_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.weight_out = rsp_w_ff;
   assign rsp_bus.status     = rsp_st_ff;

   // bucket heads: entry index plus one, zero is an empty chain
   s2dh_ram #(.WIDTH(PTR_W), .DEPTH(BUCKET_COUNT)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_en   (head_rd_en),
      .rd_addr (bkt_ff),
      .rd_data (head_rd)
   );

   // entry pool: keys, weight and chain link
   s2dh_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRY_CAPACITY)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_raw)
   );

   s2dh_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ar_req (ar_req),
      .ar_rsp (ar_rsp)
   );

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= PTR_W'(ENTRY_CAPACITY))
      else $error("entry count above capacity");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (used_ff == $past(used_ff)) || (used_ff == PTR_W'($past(used_ff) + 1'b1)))
      else $error("entry count jumped");

   a_head_write: assert property (@(posedge clock) disable iff (reset)
      (head_wr_en && state_ff != CS_CLEAR) |-> (new_ff && wr_ff))
      else $error("bucket head written without a new entry");

   a_arith_done: assert property (@(posedge clock) disable iff (reset)
      ar_rsp.done |-> (state_ff == CS_WAIT))
      else $error("arithmetic result with no update pending");

endmodule
